// ----- sv/emc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emc_pkg
// Shared types, codes and command encodings of the ElGamal engine.
// ----------------------------------------------------------------------------
package emc_pkg;

	localparam int FIELD_BITS = 32;

	localparam logic [1:0] OP_PUBLIC  = 2'd0;
	localparam logic [1:0] OP_ENCRYPT = 2'd1;
	localparam logic [1:0] OP_DECRYPT = 2'd2;
	localparam logic [1:0] OP_UNUSED  = 2'd3;

	localparam logic [1:0] CFG_MODULUS   = 2'd0;
	localparam logic [1:0] CFG_GENERATOR = 2'd1;
	localparam logic [1:0] CFG_PRIVATE   = 2'd2;

	typedef struct packed {
		logic [1:0]            operation;
		logic [FIELD_BITS-1:0] nonce;
		logic [FIELD_BITS-1:0] message;
		logic [FIELD_BITS-1:0] cipher_first;
		logic [FIELD_BITS-1:0] cipher_second;
	} in_word_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] value_first;
		logic [FIELD_BITS-1:0] value_second;
		logic [FIELD_BITS-1:0] shared_secret;
		logic                  error;
	} out_word_t;

	typedef enum logic [3:0] {
		C_NONE,
		C_LATCH,
		C_POW_SETUP,
		C_POW_MUL,
		C_POW_SQR,
		C_EXP_SHIFT,
		C_SAVE_Y,
		C_SAVE_KEY,
		C_SAVE_V1,
		C_ENC_V2,
		C_INV_INIT,
		C_DIV,
		C_INV_MUL,
		C_INV_STEP,
		C_DEC_V1,
		C_FINISH
	} cmd_code_t;

	typedef enum logic [1:0] {
		PS_GEN_PRIV,
		PS_Y_NONCE,
		PS_GEN_NONCE,
		PS_C1_PRIV
	} pow_sel_t;

	typedef enum logic [2:0] {
		D_BASE,
		D_ACC,
		D_V2,
		D_PROD,
		D_V1
	} mul_dst_t;

	typedef enum logic [2:0] {
		PH_PUB,
		PH_ENC_Y,
		PH_ENC_KEY,
		PH_ENC_V1,
		PH_DEC_KEY
	} phase_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CHECK,
		S_POW_SETUP,
		S_POW_WSETUP,
		S_POW_TEST,
		S_POW_WMUL,
		S_POW_SHIFT,
		S_POW_SQTEST,
		S_POW_WSQR,
		S_POW_END,
		S_ENC_V2,
		S_ENC_WV2,
		S_INV_INIT,
		S_INV_TEST,
		S_INV_WDIV,
		S_INV_MUL,
		S_INV_WMUL,
		S_INV_STEP,
		S_DEC_WV1,
		S_FIN
	} state_t;

	typedef struct packed {
		cmd_code_t code;
		pow_sel_t  pow_sel;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       q_small;
		logic       exp_zero;
		logic       exp_lsb;
		logic       r1_gt1;
		logic       r1_zero;
		logic       mul_done;
		logic       div_done;
		logic       out_busy;
	} status_t;

endpackage

// ----- sv/emc_modmul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emc_modmul
// Bit-serial modular multiplier, MSB first, one bit of b per cycle.
// Requires a < q; b may be any value, so a = 1 reduces b modulo q.
// ----------------------------------------------------------------------------
module emc_modmul #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic [W-1:0] q,
	output logic [W-1:0] result,
	output logic         done
);
	localparam int CW = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  a_q;
	logic [W-1:0]  b_q;
	logic [W:0]    dbl;
	logic [W:0]    dbl_red;
	logic [W:0]    sum;
	logic [W:0]    sum_red;
	logic [W:0]    q_ext;

	always_comb begin
		q_ext   = {1'b0, q};
		dbl     = {acc_q, 1'b0};
		dbl_red = (dbl >= q_ext) ? dbl - q_ext : dbl;
		sum     = dbl_red + (b_q[W-1] ? {1'b0, a_q} : '0);
		sum_red = (sum >= q_ext) ? sum - q_ext : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			acc_q <= sum_red[W-1:0];
			b_q   <= {b_q[W-2:0], 1'b0};
		end
	end

	assign result = acc_q;
	assign done   = done_q;

endmodule

// ----- sv/emc_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emc_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module emc_divider #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder,
	output logic         done
);
	localparam int CW = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  n_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  d_q;
	logic [W:0]    trial;
	logic          fits;

	always_comb begin
		trial = {rem_q, n_q[W-1]};
		fits  = (trial >= {1'b0, d_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= dividend;
			rem_q <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			n_q   <= {n_q[W-2:0], fits};
			rem_q <= fits ? W'(trial - {1'b0, d_q}) : trial[W-1:0];
		end
	end

	assign quotient  = n_q;
	assign remainder = rem_q;
	assign done      = done_q;

endmodule

// ----- sv/emc_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emc_datapath
// Configuration, working registers, multiplier, divider and output word.
// ----------------------------------------------------------------------------
module emc_datapath #(
	parameter int W = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  emc_pkg::cmd_t     cmd,
	output emc_pkg::status_t  status,
	input  emc_pkg::in_word_t in_data,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [W-1:0]      cfg_data,
	output logic              out_valid,
	input  logic              out_stall,
	output emc_pkg::out_word_t out_data
);
	logic [W-1:0] mod_q, gen_q, priv_q;
	logic [1:0]   op_q;
	logic [W-1:0] nonce_q, msg_q, c1_q, c2_q;
	logic [W-1:0] base_q, exp_q, acc_q, y_q, key_q, v1_q, v2_q, prod_q;
	logic [W-1:0] r0_q, r1_q, t0_q, t1_q;
	emc_pkg::mul_dst_t mul_dst_q;
	logic         out_valid_q;
	emc_pkg::out_word_t out_q;
	emc_pkg::out_word_t fin_word;

	logic         mul_start, div_start, mul_done, div_done;
	logic [W-1:0] mul_a, mul_b, mul_res, quo, rem;
	logic [W-1:0] pow_base, pow_exp, t_next;
	logic         q_small;

	emc_modmul #(.W(W)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.q(mod_q), .result(mul_res), .done(mul_done)
	);

	emc_divider #(.W(W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(r0_q),
		.divisor(r1_q), .quotient(quo), .remainder(rem), .done(div_done)
	);

	assign q_small = (mod_q < W'(2));
	assign t_next  = t0_q - prod_q + ((t0_q < prod_q) ? mod_q : '0);

	always_comb begin
		unique case (cmd.pow_sel)
			emc_pkg::PS_GEN_PRIV:  begin pow_base = gen_q; pow_exp = priv_q;  end
			emc_pkg::PS_Y_NONCE:   begin pow_base = y_q;   pow_exp = nonce_q; end
			emc_pkg::PS_GEN_NONCE: begin pow_base = gen_q; pow_exp = nonce_q; end
			emc_pkg::PS_C1_PRIV:   begin pow_base = c1_q;  pow_exp = priv_q;  end
			default:               begin pow_base = gen_q; pow_exp = priv_q;  end
		endcase
	end

	always_comb begin
		mul_start = 1'b0;
		div_start = 1'b0;
		mul_a     = W'(1);
		mul_b     = '0;
		unique case (cmd.code)
			emc_pkg::C_POW_SETUP: begin mul_start = 1'b1; mul_b = pow_base; end
			emc_pkg::C_POW_MUL: begin
				mul_start = 1'b1; mul_a = acc_q; mul_b = base_q;
			end
			emc_pkg::C_POW_SQR: begin
				mul_start = 1'b1; mul_a = base_q; mul_b = base_q;
			end
			emc_pkg::C_ENC_V2: begin
				mul_start = 1'b1; mul_a = key_q; mul_b = msg_q;
			end
			emc_pkg::C_INV_MUL: begin
				mul_start = 1'b1; mul_a = t1_q; mul_b = quo;
			end
			emc_pkg::C_DEC_V1: begin
				mul_start = 1'b1; mul_a = t1_q; mul_b = c2_q;
			end
			emc_pkg::C_DIV: div_start = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		fin_word = '0;
		if (q_small) begin
			fin_word.error = (op_q == emc_pkg::OP_DECRYPT);
		end else begin
			case (op_q)
				emc_pkg::OP_PUBLIC: fin_word.value_first = 32'(v1_q);
				emc_pkg::OP_ENCRYPT: begin
					fin_word.value_first   = 32'(v1_q);
					fin_word.value_second  = 32'(v2_q);
					fin_word.shared_secret = 32'(key_q);
				end
				emc_pkg::OP_DECRYPT: begin
					fin_word.shared_secret = 32'(key_q);
					fin_word.error         = (r1_q == '0);
					fin_word.value_first   = (r1_q == '0) ? '0 : 32'(v1_q);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q       <= W'(2);
			gen_q       <= '0;
			priv_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					emc_pkg::CFG_MODULUS:   mod_q  <= cfg_data;
					emc_pkg::CFG_GENERATOR: gen_q  <= cfg_data;
					emc_pkg::CFG_PRIVATE:   priv_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.code == emc_pkg::C_FINISH)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mul_done) begin
			unique case (mul_dst_q)
				emc_pkg::D_BASE: base_q <= mul_res;
				emc_pkg::D_ACC:  acc_q  <= mul_res;
				emc_pkg::D_V2:   v2_q   <= mul_res;
				emc_pkg::D_PROD: prod_q <= mul_res;
				emc_pkg::D_V1:   v1_q   <= mul_res;
				default: ;
			endcase
		end
		unique case (cmd.code)
			emc_pkg::C_LATCH: begin
				op_q    <= in_data.operation;
				nonce_q <= W'(in_data.nonce);
				msg_q   <= W'(in_data.message);
				c1_q    <= W'(in_data.cipher_first);
				c2_q    <= W'(in_data.cipher_second);
			end
			emc_pkg::C_POW_SETUP: begin
				mul_dst_q <= emc_pkg::D_BASE;
				exp_q     <= pow_exp;
				acc_q     <= W'(1);
			end
			emc_pkg::C_POW_MUL:   mul_dst_q <= emc_pkg::D_ACC;
			emc_pkg::C_POW_SQR:   mul_dst_q <= emc_pkg::D_BASE;
			emc_pkg::C_ENC_V2:    mul_dst_q <= emc_pkg::D_V2;
			emc_pkg::C_INV_MUL:   mul_dst_q <= emc_pkg::D_PROD;
			emc_pkg::C_DEC_V1:    mul_dst_q <= emc_pkg::D_V1;
			emc_pkg::C_EXP_SHIFT: exp_q <= exp_q >> 1;
			emc_pkg::C_SAVE_Y:    y_q   <= acc_q;
			emc_pkg::C_SAVE_KEY:  key_q <= acc_q;
			emc_pkg::C_SAVE_V1:   v1_q  <= acc_q;
			emc_pkg::C_INV_INIT: begin
				r0_q <= mod_q;
				r1_q <= key_q;
				t0_q <= '0;
				t1_q <= W'(1);
			end
			emc_pkg::C_INV_STEP: begin
				r0_q <= r1_q;
				r1_q <= rem;
				t0_q <= t1_q;
				t1_q <= t_next;
			end
			emc_pkg::C_FINISH: out_q <= fin_word;
			default: ;
		endcase
	end

	always_comb begin
		status          = '0;
		status.op       = op_q;
		status.q_small  = q_small;
		status.exp_zero = (exp_q == '0);
		status.exp_lsb  = exp_q[0];
		status.r1_gt1   = (r1_q > W'(1));
		status.r1_zero  = (r1_q == '0);
		status.mul_done = mul_done;
		status.div_done = div_done;
		status.out_busy = out_valid_q && out_stall;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.code == emc_pkg::C_FINISH) |-> !(out_valid_q && out_stall))
		else $error("result word overwritten while stalled");
	a_mul_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(mul_done && !q_small) |-> (mul_res < mod_q))
		else $error("multiplier result not reduced");
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(div_done && (r1_q != '0)) |-> (rem < r1_q))
		else $error("divider remainder out of range");

endmodule

// ----- sv/emc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emc_ctrl
// Sequencer for exponentiation, encryption, Euclid inversion and decryption.
// ----------------------------------------------------------------------------
module emc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  emc_pkg::status_t status,
	output emc_pkg::cmd_t    cmd
);
	emc_pkg::state_t state_q, state_d;
	emc_pkg::phase_t phase_q, phase_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= emc_pkg::S_IDLE;
			phase_q <= emc_pkg::PH_PUB;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		phase_d     = phase_q;
		cmd.code    = emc_pkg::C_NONE;
		cmd.pow_sel = emc_pkg::PS_GEN_PRIV;
		unique case (phase_q)
			emc_pkg::PH_ENC_KEY: cmd.pow_sel = emc_pkg::PS_Y_NONCE;
			emc_pkg::PH_ENC_V1:  cmd.pow_sel = emc_pkg::PS_GEN_NONCE;
			emc_pkg::PH_DEC_KEY: cmd.pow_sel = emc_pkg::PS_C1_PRIV;
			default:             cmd.pow_sel = emc_pkg::PS_GEN_PRIV;
		endcase
		unique case (state_q)
			emc_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.code = emc_pkg::C_LATCH;
					state_d  = emc_pkg::S_CHECK;
				end
			end
			emc_pkg::S_CHECK: begin
				if (status.q_small || status.op == emc_pkg::OP_UNUSED)
					state_d = emc_pkg::S_FIN;
				else begin
					state_d = emc_pkg::S_POW_SETUP;
					case (status.op)
						emc_pkg::OP_ENCRYPT: phase_d = emc_pkg::PH_ENC_Y;
						emc_pkg::OP_DECRYPT: phase_d = emc_pkg::PH_DEC_KEY;
						default:             phase_d = emc_pkg::PH_PUB;
					endcase
				end
			end
			emc_pkg::S_POW_SETUP: begin
				cmd.code = emc_pkg::C_POW_SETUP;
				state_d  = emc_pkg::S_POW_WSETUP;
			end
			emc_pkg::S_POW_WSETUP: if (status.mul_done) state_d = emc_pkg::S_POW_TEST;
			emc_pkg::S_POW_TEST: begin
				if (status.exp_zero)
					state_d = emc_pkg::S_POW_END;
				else if (status.exp_lsb) begin
					cmd.code = emc_pkg::C_POW_MUL;
					state_d  = emc_pkg::S_POW_WMUL;
				end else
					state_d = emc_pkg::S_POW_SHIFT;
			end
			emc_pkg::S_POW_WMUL: if (status.mul_done) state_d = emc_pkg::S_POW_SHIFT;
			emc_pkg::S_POW_SHIFT: begin
				cmd.code = emc_pkg::C_EXP_SHIFT;
				state_d  = emc_pkg::S_POW_SQTEST;
			end
			emc_pkg::S_POW_SQTEST: begin
				if (status.exp_zero)
					state_d = emc_pkg::S_POW_END;
				else begin
					cmd.code = emc_pkg::C_POW_SQR;
					state_d  = emc_pkg::S_POW_WSQR;
				end
			end
			emc_pkg::S_POW_WSQR: if (status.mul_done) state_d = emc_pkg::S_POW_TEST;
			emc_pkg::S_POW_END: begin
				unique case (phase_q)
					emc_pkg::PH_ENC_Y: begin
						cmd.code = emc_pkg::C_SAVE_Y;
						phase_d  = emc_pkg::PH_ENC_KEY;
						state_d  = emc_pkg::S_POW_SETUP;
					end
					emc_pkg::PH_ENC_KEY: begin
						cmd.code = emc_pkg::C_SAVE_KEY;
						phase_d  = emc_pkg::PH_ENC_V1;
						state_d  = emc_pkg::S_POW_SETUP;
					end
					emc_pkg::PH_ENC_V1: begin
						cmd.code = emc_pkg::C_SAVE_V1;
						state_d  = emc_pkg::S_ENC_V2;
					end
					emc_pkg::PH_DEC_KEY: begin
						cmd.code = emc_pkg::C_SAVE_KEY;
						state_d  = emc_pkg::S_INV_INIT;
					end
					default: begin
						cmd.code = emc_pkg::C_SAVE_V1;
						state_d  = emc_pkg::S_FIN;
					end
				endcase
			end
			emc_pkg::S_ENC_V2: begin
				cmd.code = emc_pkg::C_ENC_V2;
				state_d  = emc_pkg::S_ENC_WV2;
			end
			emc_pkg::S_ENC_WV2: if (status.mul_done) state_d = emc_pkg::S_FIN;
			emc_pkg::S_INV_INIT: begin
				cmd.code = emc_pkg::C_INV_INIT;
				state_d  = emc_pkg::S_INV_TEST;
			end
			emc_pkg::S_INV_TEST: begin
				if (status.r1_gt1) begin
					cmd.code = emc_pkg::C_DIV;
					state_d  = emc_pkg::S_INV_WDIV;
				end else if (status.r1_zero)
					state_d = emc_pkg::S_FIN;
				else begin
					cmd.code = emc_pkg::C_DEC_V1;
					state_d  = emc_pkg::S_DEC_WV1;
				end
			end
			emc_pkg::S_INV_WDIV: if (status.div_done) state_d = emc_pkg::S_INV_MUL;
			emc_pkg::S_INV_MUL: begin
				cmd.code = emc_pkg::C_INV_MUL;
				state_d  = emc_pkg::S_INV_WMUL;
			end
			emc_pkg::S_INV_WMUL: if (status.mul_done) state_d = emc_pkg::S_INV_STEP;
			emc_pkg::S_INV_STEP: begin
				cmd.code = emc_pkg::C_INV_STEP;
				state_d  = emc_pkg::S_INV_TEST;
			end
			emc_pkg::S_DEC_WV1: if (status.mul_done) state_d = emc_pkg::S_FIN;
			emc_pkg::S_FIN: begin
				if (!status.out_busy) begin
					cmd.code = emc_pkg::C_FINISH;
					state_d  = emc_pkg::S_IDLE;
				end
			end
			default: state_d = emc_pkg::S_IDLE;
		endcase
	end

	assign in_stall = (state_q != emc_pkg::S_IDLE);

endmodule

// ----- sv/elgamal_modular_crypto_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elgamal_modular_crypto_core
// ElGamal public key, encryption and decryption over a configured modulus.
// ----------------------------------------------------------------------------
// One request at a time. Every modular multiply runs on a bit-serial
// multiplier, so that unit sets the rate: a public key needs up to
// 2*WORD_BITS multiplies, encrypt up to 6*WORD_BITS+1, decrypt up to
// 2*WORD_BITS exponent multiplies plus, per Euclid round, one division
// and one multiply. The input is taken only between requests; a finished
// result waits in the output register while the next request runs.
module elgamal_modular_crypto_core #(
	parameter int WORD_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  emc_pkg::in_word_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output emc_pkg::out_word_t  out_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [WORD_BITS-1:0] cfg_data
);
	emc_pkg::cmd_t    cmd;
	emc_pkg::status_t status;

	emc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.status(status), .cmd(cmd)
	);

	emc_datapath #(.W(WORD_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.in_data(in_data), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .out_valid(out_valid), .out_stall(out_stall),
		.out_data(out_data)
	);

endmodule
